// ===== rtl/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted-table search block
// Field widths, search engine states and the result record.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int CNT_W  = 8;   // element_count register width
    localparam int IDX_W  = 7;   // entry_index / match_index width
    localparam int DATA_W = 32;  // table entry and key width

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } sts_state_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } sts_result_t;

endpackage

// ===== rtl/sts_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_req_if: request channel
// Valid/ready handshake carrying one write or search request.
// ----------------------------------------------------------------------------
interface sts_req_if;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [6:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] search_key;

    modport source (output valid, output opcode, output entry_index,
                    output entry_value, output search_key, input ready);
    modport sink   (input valid, input opcode, input entry_index,
                    input entry_value, input search_key, output ready);

endinterface

// ===== rtl/sts_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_rsp_if: response channel
// Valid/ready handshake carrying one search result.
// ----------------------------------------------------------------------------
interface sts_rsp_if;

    logic       valid;
    logic       ready;
    logic       found;
    logic [6:0] match_index;

    modport source (output valid, output found, output match_index, input ready);
    modport sink   (input valid, input found, input match_index, output ready);

endinterface

// ===== rtl/sts_table_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_table_mem: table storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sts_table_mem
    import sts_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/sts_search_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_search_fsm: binary search sequencer
// Issues one table read per probe and narrows the bounds on the read data.
// ----------------------------------------------------------------------------
module sts_search_fsm
    import sts_pkg::*;
#(
    parameter int AW = 7,
    parameter int BW = 9
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,      // search request accepted
    input  logic signed [DATA_W-1:0] key,
    input  logic [BW-1:0]            count,      // clamped element count
    output logic                     idle,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic signed [DATA_W-1:0] rd_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output sts_result_t              res
);

    // Bounds are kept as [lo, hi) so both stay non-negative.
    function automatic logic [BW-1:0] mid_of(input logic [BW-1:0] lo,
                                             input logic [BW-1:0] hi);
        logic [BW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - {{BW{1'b0}}, 1'b1};
        return sum[BW:1];
    endfunction

    sts_state_t               state_reg, state_next;
    logic [BW-1:0]            lo_reg, lo_next;
    logic [BW-1:0]            hi_reg, hi_next;
    logic [BW-1:0]            mid_reg, mid_next;
    logic signed [DATA_W-1:0] key_reg;
    sts_result_t              res_reg, res_next;

    logic                     hit;
    logic                     go_left;
    logic [BW-1:0]            lo_cand;
    logic [BW-1:0]            hi_cand;

    assign hit     = (rd_data == key_reg);
    assign go_left = (rd_data > key_reg);
    assign lo_cand = go_left ? lo_reg : (mid_reg + {{(BW-1){1'b0}}, 1'b1});
    assign hi_cand = go_left ? mid_reg : hi_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (count == '0) ? ST_DONE : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (hit || (lo_cand >= hi_cand))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        lo_next  = lo_reg;
        hi_next  = hi_reg;
        mid_next = mid_reg;
        res_next = res_reg;
        rd_en    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                lo_next  = '0;
                hi_next  = count;
                mid_next = mid_of('0, count);
                res_next = '0;
                rd_en    = start && (count != '0);
            end
            ST_PROBE:
            begin
                lo_next  = lo_cand;
                hi_next  = hi_cand;
                mid_next = mid_of(lo_cand, hi_cand);
                if (hit)
                begin
                    res_next.found       = 1'b1;
                    res_next.match_index = mid_reg[IDX_W-1:0];
                end
                rd_en = !hit && (lo_cand < hi_cand);
            end
            ST_DONE:
            begin
                rd_en = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign rd_addr   = mid_next[AW-1:0];
    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        res_reg <= res_next;
        if (start && (state_reg == ST_IDLE))
        begin
            key_reg <= key;
        end
    end

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// Search: an accepted search makes P probes, at most floor(log2(count)) + 1
//   (8 for 128); rsp.valid rises when the response register takes the result.
// Requests: a write leaves the engine idle; no request is taken during a search.
//   The single table read port, one probe per cycle, paces each search.
// Reset: element_count clears to 0; the table is undefined until written.
// ----------------------------------------------------------------------------
// sorted_table_binary_search: sorted table with binary search lookup
// Stores signed 32-bit entries by index and looks up keys over the first
// element_count entries (clamped to the depth), one memory probe per cycle.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    sts_req_if.sink          req,
    sts_rsp_if.source        rsp
);

    // Table address width and bound width. Bounds must hold both the clamped
    // count and the depth itself.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BW = (AW + 1 > CNT_W + 1) ? AW + 1 : CNT_W + 1;
    localparam logic [BW-1:0] DEPTH_B = BW'(TABLE_DEPTH);

    logic [CNT_W-1:0]         count_reg;
    logic [BW-1:0]            count_ext;
    logic [BW-1:0]            search_count;

    logic                     req_fire;
    logic                     wr_fire;
    logic                     srch_fire;
    logic [BW-1:0]            wr_index_ext;
    logic                     wr_in_range;

    logic                     fsm_idle;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     res_valid;
    logic                     res_ready;
    sts_result_t              res;

    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    sts_result_t              rsp_data_reg;

    // Element count register; clamp to the table depth for the search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            count_reg <= cfg_wr_data;
        end
    end

    assign count_ext    = BW'(count_reg);
    assign search_count = (count_ext > DEPTH_B) ? DEPTH_B : count_ext;

    // Request decode: take requests only while the search engine is idle.
    assign req.ready    = fsm_idle;
    assign req_fire     = req.valid && req.ready;
    assign wr_fire      = req_fire && (req.opcode == OP_WRITE);
    assign srch_fire    = req_fire && (req.opcode == OP_SEARCH);

    // Drop writes beyond the table.
    assign wr_index_ext = BW'(req.entry_index);
    assign wr_in_range  = (wr_index_ext < DEPTH_B);

    sts_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_fire && wr_in_range),
        .wr_addr (wr_index_ext[AW-1:0]),
        .wr_data (req.entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sts_search_fsm #(
        .AW (AW),
        .BW (BW)
    ) u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (srch_fire),
        .key       (req.search_key),
        .count     (search_count),
        .idle      (fsm_idle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Response register: load when empty or being drained, hold otherwise.
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.found       = rsp_data_reg.found;
    assign rsp.match_index = rsp_data_reg.match_index;

endmodule

// ===== rtl/sts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_checker: port-level checks for the sorted-table search block
// Watches request/response ordering and result encoding.
// ----------------------------------------------------------------------------
module sts_checker
    import sts_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             req_opcode,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_found,
    input logic [IDX_W-1:0] rsp_match_index
);

    // A search request busies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_opcode == OP_SEARCH)) |=> !req_ready)
    else $error("request taken right after a search request");

    // A write request never produces a response.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_opcode == OP_WRITE) && !rsp_valid)
        |=> !rsp_valid)
    else $error("response appeared after a write request");

    // A miss reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_found) |-> (rsp_match_index == '0))
    else $error("miss with nonzero index");

    // A stalled response holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
        (rsp_valid && $stable(rsp_found) && $stable(rsp_match_index)))
    else $error("stalled response changed");

endmodule

bind sorted_table_binary_search sts_checker u_sts_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_opcode      (req.opcode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_found       (rsp.found),
    .rsp_match_index (rsp.match_index)
);

// ===== tb/sts_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_search_checker: lookup predictor and result comparator
// Mirrors the table and the element_count register from the observed
// channels, predicts one result per accepted search request and compares
// every accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module sts_search_checker
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    sts_req_if               req,
    sts_rsp_if               rsp,
    output int               error_count,
    output int               results_pending
);

    localparam int REPORT_LIMIT = 10;

    logic signed [DATA_W-1:0] shadow_table [TABLE_DEPTH];
    logic [CNT_W-1:0]         element_count;
    sts_result_t              lookup_results_due [$];
    sts_result_t              oldest_due;

    // Walk the probe sequence over [0, span-1] exactly as the block does.
    function automatic sts_result_t predict_lookup(input logic signed [DATA_W-1:0] key);
        int          span;
        int          lo;
        int          hi;
        int          mid;
        sts_result_t res;
        span = (element_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(element_count);
        lo = 0;
        hi = span - 1;
        res.found = 1'b0;
        res.match_index = '0;
        while (lo <= hi && !res.found) begin
            mid = (lo + hi) / 2;
            if (shadow_table[mid] == key) begin
                res.found = 1'b1;
                res.match_index = IDX_W'(mid);
            end else if (shadow_table[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            element_count = '0;
            lookup_results_due.delete();
            error_count = 0;
            results_pending = 0;
        end else begin
            if (cfg_wr_en) begin
                element_count = cfg_wr_data;
            end

            if (req.valid && req.ready) begin
                if (req.opcode == OP_WRITE) begin
                    if (req.entry_index < TABLE_DEPTH) begin
                        shadow_table[req.entry_index] = req.entry_value;
                    end
                end else begin
                    lookup_results_due.push_back(predict_lookup(req.search_key));
                end
            end

            if (rsp.valid && rsp.ready) begin
                if (lookup_results_due.size() == 0) begin
                    if (error_count < REPORT_LIMIT) begin
                        $display("[%0t] unexpected response: found=%0b match_index=%0d",
                                 $time, rsp.found, rsp.match_index);
                    end
                    error_count++;
                end else begin
                    oldest_due = lookup_results_due.pop_front();
                    if (rsp.found !== oldest_due.found ||
                        rsp.match_index !== oldest_due.match_index) begin
                        if (error_count < REPORT_LIMIT) begin
                            $display("[%0t] response mismatch: found exp=%0b act=%0b, %s",
                                     $time, oldest_due.found, rsp.found,
                                     $sformatf("match_index exp=%0d act=%0d",
                                               oldest_due.match_index, rsp.match_index));
                        end
                        error_count++;
                    end
                end
            end

            results_pending = lookup_results_due.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: sorted-table binary search testbench
// Loads sorted tables (wide and dense with duplicates), sweeps element_count
// from empty to beyond the table depth, and mixes lookups with in-order and
// order-breaking entry writes under random stalls on both channels. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
    import sts_pkg::*;

    localparam int TABLE_DEPTH    = 128;
    localparam int MAX_GAP        = 6;
    localparam int LONG_HOLD      = 250;   // response-side hold-off, in cycles
    localparam int SETTLE_CYCLES  = 16;    // covers the longest search with margin
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 30;

    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    int               error_count;
    int               results_pending;

    // Set per phase: both sides run back to back, no idle cycles.
    bit               no_idle = 1'b0;
    int               responses_taken = 0;

    // Stimulus-side copy of the table contents, used only to pick keys
    // that land on stored entries and bounds that keep the order.
    logic signed [DATA_W-1:0] table_image [TABLE_DEPTH];
    int                       element_span = 0;

    sts_req_if req_ch ();
    sts_rsp_if rsp_ch ();

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    sts_search_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request driver. Enter and leave at a falling edge; valid stays high
    // after acceptance so back-to-back requests never drop it in between.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] value,
                                input logic signed [DATA_W-1:0] key);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= op;
        req_ch.entry_index <= idx;
        req_ch.entry_value <= value;
        req_ch.search_key  <= key;
        // Hold the request until the block takes it.
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Store one entry; the key field carries noise.
    task automatic write_entry(input logic [IDX_W-1:0] idx,
                               input logic signed [DATA_W-1:0] value);
        table_image[idx] = value;
        send_request(OP_WRITE, idx, value, $urandom);
    endtask

    // Search for one key; index and value fields carry noise.
    task automatic lookup(input logic signed [DATA_W-1:0] key);
        send_request(OP_SEARCH, IDX_W'($urandom), $urandom, key);
    endtask

    // Drain every pending response, let any trailing write retire, then
    // update the register while the block is idle.
    task automatic set_element_count(input logic [CNT_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        element_span = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
    endtask

    // Fill all entries in ascending order. Wide tables run from the most
    // negative to the most positive value; dense ones repeat values often.
    task automatic load_table(input bit dense);
        longint acc;
        int     i;
        acc = dense ? longint'($urandom_range(0, 400)) - 200 : longint'(KEY_MIN);
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (!dense && i == TABLE_DEPTH - 1)
            begin
                acc = longint'(KEY_MAX);
            end
            write_entry(IDX_W'(i), DATA_W'(acc));
            acc += dense ? $urandom_range(0, 2) : $urandom_range(0, 1 << 26);
            if (acc > longint'(KEY_MAX))
            begin
                acc = longint'(KEY_MAX);
            end
        end
    endtask

    // Mostly keys that sit in the searched range, some near misses, some
    // arbitrary words and the corner values.
    function automatic logic signed [DATA_W-1:0] pick_key();
        int                       pick;
        logic signed [DATA_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (element_span > 0 && pick < 50)
        begin
            k = table_image[$urandom_range(0, element_span - 1)];
        end
        else if (element_span > 0 && pick < 70)
        begin
            k = table_image[$urandom_range(0, element_span - 1)];
            k = ($urandom_range(0, 1) == 1) ? k + 1 : k - 1;
        end
        else if (pick < 90)
        begin
            k = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                default: k = '1;
            endcase
        end
        return k;
    endfunction

    // One random request: lookups dominate; most writes keep the order,
    // a few drop an arbitrary value anywhere and break it.
    task automatic random_item();
        int                       pick;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] lo_bound;
        logic signed [DATA_W-1:0] hi_bound;
        longint                   room;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            lookup(pick_key());
        end
        else if (pick < 95)
        begin
            idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            lo_bound = (idx == 0) ? KEY_MIN : table_image[idx - 1];
            hi_bound = (idx == TABLE_DEPTH - 1) ? KEY_MAX : table_image[idx + 1];
            room = longint'(hi_bound) - longint'(lo_bound) + 1;
            if (room < 1)
            begin
                room = 1;
            end
            write_entry(idx, DATA_W'(longint'(lo_bound) + longint'($urandom) % room));
        end
        else
        begin
            write_entry(IDX_W'($urandom), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: draw a stall per response, and twice hold off for a
    // long stretch so the block backs up and stalls its request channel.
    // ------------------------------------------------------------------------
    initial
    begin : response_sink
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (responses_taken == 60 || responses_taken == 200)
            begin
                stall = LONG_HOLD;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            responses_taken++;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("[%0t] watchdog: no request or response accepted for %0d cycles",
                 $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int n;
        int count_plan [PHASE_COUNT];

        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_WRITE;
        req_ch.entry_index = '0;
        req_ch.entry_value = '0;
        req_ch.search_key  = '0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty table straight out of reset: every search misses without
        // touching a single entry.
        lookup(KEY_MIN);
        lookup(KEY_MAX);
        lookup('0);
        lookup('1);

        // Wide sorted table with both extremes at the ends.
        load_table(1'b0);

        // Count beyond the depth: the search covers the whole table.
        set_element_count(8'd255);
        lookup(KEY_MIN);
        lookup(KEY_MAX);
        lookup(table_image[63]);
        lookup(table_image[64]);
        lookup(table_image[100]);
        lookup(table_image[40] + 1);
        lookup('0);
        lookup('1);

        // Single and two-entry ranges.
        set_element_count(8'd1);
        lookup(table_image[0]);
        lookup(KEY_MAX);
        set_element_count(8'd2);
        lookup(table_image[1]);
        lookup(table_image[0]);

        // Break the order at the top, search through it, then restore.
        write_entry(IDX_W'(TABLE_DEPTH - 1), KEY_MIN);
        set_element_count(8'd128);
        lookup(KEY_MIN);
        lookup(table_image[126]);
        write_entry(IDX_W'(TABLE_DEPTH - 1), KEY_MAX);

        // Random phases, each under its own element_count. Reload the table
        // twice: once dense with duplicates, once wide again.
        count_plan = '{128, 1, 255, 2, 0, 64, 127, 129, 3, 100, 0, 128};
        count_plan[10] = $urandom_range(4, 254);
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            no_idle = (phase % 3 == 2);
            if (phase == 4)
            begin
                load_table(1'b1);
            end
            else if (phase == 8)
            begin
                load_table(1'b0);
            end
            set_element_count(CNT_W'(count_plan[phase]));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item();
            end
        end

        // Drop valid, wait for the last responses, then let the block settle.
        req_ch.valid <= 1'b0;
        no_idle = 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sorted_table_binary_search.f =====
rtl/sts_pkg.sv
rtl/sts_req_if.sv
rtl/sts_rsp_if.sv
rtl/sts_table_mem.sv
rtl/sts_search_fsm.sv
rtl/sorted_table_binary_search.sv
rtl/sts_checker.sv
tb/sts_search_checker.sv
tb/tb.sv
